// File: src/gf2pi_pkg.sv
// ----------------------------------------------------------------------------
// gf2pi_pkg
// Shared constants for the GF(2) polynomial inverter.
// ----------------------------------------------------------------------------
package gf2pi_pkg;

    localparam int FIELD_DEGREE_DEF = 8;
    localparam int MOD_RESET        = 283;
    localparam int REG_MODULUS      = 0;

endpackage

// File: src/gf2_poly_inverse_euclid_unit.sv
// ----------------------------------------------------------------------------
// gf2_poly_inverse_euclid_unit
// GF(2)[x] inverse modulo a configured modulus, extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// The operand passes a chain of 2*FIELD_DEGREE Euclidean stages, one register
// each; every stage cancels the leading term of the older remainder against
// the newer one and swaps the two when the order flips, cofactors following.
// A transaction enters every cycle unless the receiver stalls the chain; its
// result passes the stage registers and then the output register before it
// is offered. Zero operand, modulus without top bit, or gcd other than one
// give no_inverse high and inverse zero.
module gf2_poly_inverse_euclid_unit #(
    parameter int FIELD_DEGREE = gf2pi_pkg::FIELD_DEGREE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [FIELD_DEGREE-1:0] i_operand_poly,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [FIELD_DEGREE-1:0] o_inverse_poly,
    output logic                    o_no_inverse
);
    localparam int M  = FIELD_DEGREE;
    localparam int N  = 2*M;

    logic [M:0] r_modulus;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'(gf2pi_pkg::REG_MODULUS)) ? 32'(r_modulus) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= (M+1)'(gf2pi_pkg::MOD_RESET);
        end else if (psel && penable && pwrite && paddr[2] == 1'(gf2pi_pkg::REG_MODULUS)) begin
            r_modulus <= pwdata[M:0];
        end
    end

    logic          c_valid [N+1];
    logic          c_ready [N+1];
    logic [M:0]    c_r [N+1], c_s [N+1], c_u [N+1], c_v [N+1];
    logic          c_ok [N+1];

    assign c_valid[0] = i_valid;
    assign o_ready    = c_ready[0];
    assign c_r[0]     = r_modulus;
    assign c_s[0]     = {1'b0, i_operand_poly};
    assign c_u[0]     = '0;
    assign c_v[0]     = (M+1)'(1);
    assign c_ok[0]    = r_modulus[M] && (i_operand_poly != '0);

    for (genvar k = 0; k < N; k++) begin : g_stage
        gf2pi_stage #(.M(M)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(c_valid[k]), .o_ready(c_ready[k]),
            .i_r(c_r[k]), .i_s(c_s[k]), .i_u(c_u[k]), .i_v(c_v[k]),
            .i_ok(c_ok[k]),
            .o_valid(c_valid[k+1]), .i_ready(c_ready[k+1]),
            .o_r(c_r[k+1]), .o_s(c_s[k+1]), .o_u(c_u[k+1]), .o_v(c_v[k+1]),
            .o_ok(c_ok[k+1])
        );
    end

    // After 2M steps r holds the gcd and u its operand cofactor.
    logic            r_out_valid;
    logic [M-1:0]    r_inv;
    logic            r_none;
    logic            w_good;

    assign w_good = c_ok[N] && (c_r[N] == (M+1)'(1)) && (c_s[N] == '0);
    assign c_ready[N] = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_ready[N]) begin
            r_out_valid <= c_valid[N];
        end
        if (c_ready[N]) begin
            r_inv  <= w_good ? c_u[N][M-1:0] : '0;
            r_none <= !w_good;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_inverse_poly = r_inv;
    assign o_no_inverse   = r_none;
endmodule

// File: src/gf2pi_stage.sv
// ----------------------------------------------------------------------------
// gf2pi_stage
// One step of the extended Euclidean algorithm over GF(2), held in a pipeline
// register with its valid bit; stalls when the next stage holds.
// ----------------------------------------------------------------------------
module gf2pi_stage #(
    parameter int M = gf2pi_pkg::FIELD_DEGREE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [M:0] i_r,
    input  logic [M:0] i_s,
    input  logic [M:0] i_u,
    input  logic [M:0] i_v,
    input  logic       i_ok,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [M:0] o_r,
    output logic [M:0] o_s,
    output logic [M:0] o_u,
    output logic [M:0] o_v,
    output logic       o_ok
);
    localparam int LW = $clog2(M+2);

    logic          r_valid;
    logic [M:0]    r_r, r_s, r_u, r_v;
    logic          r_ok;
    logic [M:0]    n_r, n_s, n_u, n_v;
    logic [LW-1:0] w_len_r, w_len_s, w_len_w, w_sh;
    logic [M:0]    w_r, w_u;

    // degree plus one, zero for the zero polynomial
    function automatic logic [LW-1:0] poly_len(input logic [M:0] p);
        logic [LW-1:0] len;
        len = '0;
        for (int i = 0; i <= M; i++) begin
            if (p[i]) begin
                len = LW'(i + 1);
            end
        end
        return len;
    endfunction

    assign o_ready = !r_valid || i_ready;

    // r: older remainder, s: newer remainder; u, v: their operand cofactors.
    // Cancel the leading term of r against s, swap once r drops below s.
    always_comb begin
        w_len_r = poly_len(i_r);
        w_len_s = poly_len(i_s);
        w_sh    = w_len_r - w_len_s;
        w_r     = i_r ^ (i_s << w_sh);
        w_u     = i_u ^ (i_v << w_sh);
        w_len_w = poly_len(w_r);
        n_r = i_r; n_s = i_s; n_u = i_u; n_v = i_v;
        if (w_len_s != '0 && w_len_r >= w_len_s) begin
            if (w_len_w < w_len_s) begin
                n_r = i_s; n_u = i_v;
                n_s = w_r; n_v = w_u;
            end else begin
                n_r = w_r; n_u = w_u;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_r <= n_r; r_s <= n_s; r_u <= n_u; r_v <= n_v;
            r_ok <= i_ok;
        end
    end

    assign o_valid = r_valid;
    assign o_r = r_r; assign o_s = r_s; assign o_u = r_u; assign o_v = r_v;
    assign o_ok = r_ok;
endmodule

// File: test/gf2_poly_inverse_euclid_unit_chk.sv
// ----------------------------------------------------------------------------
// gf2_poly_inverse_euclid_unit_chk
// Watches the operand and result channels and the register port, works out
// each inverse by the extended Euclidean algorithm over GF(2) and compares.
// ----------------------------------------------------------------------------
module gf2_poly_inverse_euclid_unit_chk #(
    parameter int FIELD_DEGREE = gf2pi_pkg::FIELD_DEGREE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    input  logic                    pready,
    input  logic                    i_valid,
    input  logic                    o_ready,
    input  logic [FIELD_DEGREE-1:0] i_operand_poly,
    input  logic                    o_valid,
    input  logic                    i_ready,
    input  logic [FIELD_DEGREE-1:0] o_inverse_poly,
    input  logic                    o_no_inverse,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked
);
    typedef struct packed {
        logic [FIELD_DEGREE-1:0] inverse;
        logic                    none;
    } t_inv_result;

    logic [FIELD_DEGREE:0] modulus;
    t_inv_result           inverse_q[$];

    function automatic int poly_deg(logic [FIELD_DEGREE:0] p);
        int d;
        d = -1;
        for (int i = 0; i <= FIELD_DEGREE; i++)
            if (p[i]) d = i;
        return d;
    endfunction

    function automatic t_inv_result invert(logic [FIELD_DEGREE:0] m,
                                           logic [FIELD_DEGREE-1:0] op);
        t_inv_result           res;
        logic [FIELD_DEGREE:0] r0, r1, t0, t1, q, tn, prod;
        int                    s;
        res = '{inverse: '0, none: 1'b1};
        if (op != '0 && m[FIELD_DEGREE]) begin
            r0 = m;
            r1 = {1'b0, op};
            t0 = '0;
            t1 = (FIELD_DEGREE+1)'(1);
            while (r1 != '0) begin
                q = '0;
                while (poly_deg(r0) >= poly_deg(r1)) begin
                    s = poly_deg(r0) - poly_deg(r1);
                    q[s] = 1'b1;
                    r0 ^= r1 << s;
                end
                prod = '0;
                for (int i = 0; i <= FIELD_DEGREE; i++)
                    if (q[i]) prod ^= t1 << i;
                tn = t0 ^ prod;
                {r0, r1} = {r1, r0};
                t0 = t1;
                t1 = tn;
            end
            if (r0 == (FIELD_DEGREE+1)'(1))
                res = '{inverse: t0[FIELD_DEGREE-1:0], none: 1'b0};
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_inv_result exp_r;
        if (!i_rst_n) begin
            modulus <= (FIELD_DEGREE+1)'(gf2pi_pkg::MOD_RESET);
            inverse_q.delete();
            o_fail_count <= 0;
            o_checked <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr == 3'(4 * gf2pi_pkg::REG_MODULUS))
                modulus <= pwdata[FIELD_DEGREE:0];
            if (i_valid && o_ready)
                inverse_q.push_back(invert(modulus, i_operand_poly));
            if (o_valid && i_ready) begin
                o_checked <= o_checked + 1;
                if (inverse_q.size() == 0) begin
                    $display("%0t: unexpected result inv=%h none=%b", $time,
                             o_inverse_poly, o_no_inverse);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = inverse_q.pop_front();
                    if (exp_r.inverse !== o_inverse_poly || exp_r.none !== o_no_inverse) begin
                        $display("%0t: expected inv=%h none=%b, actual inv=%h none=%b",
                                 $time, exp_r.inverse, exp_r.none, o_inverse_poly,
                                 o_no_inverse);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= inverse_q.size();
        end
    end
endmodule

// File: test/gf2_poly_inverse_euclid_unit_tb.sv
// ----------------------------------------------------------------------------
// gf2_poly_inverse_euclid_unit_tb
// Drives operands under several modulus settings with bursty input and a
// stalling receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module gf2_poly_inverse_euclid_unit_tb;
    localparam int FD  = gf2pi_pkg::FIELD_DEGREE_DEF;
    localparam int LAT = 2 * FD + 1;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic [FD-1:0] i_operand_poly = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [FD-1:0] o_inverse_poly;
    logic          o_no_inverse;
    int            fail_count, pending, checked;
    int            stall_mode = 0;

    gf2_poly_inverse_euclid_unit DUT (.*);

    gf2_poly_inverse_euclid_unit_chk chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_valid, .o_ready, .i_operand_poly, .o_valid, .i_ready, .o_inverse_poly,
        .o_no_inverse, .o_fail_count(fail_count), .o_pending(pending),
        .o_checked(checked)
    );

    always #10 i_clk = ~i_clk;

    // receiver: phases of no stall, light and heavy stall
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk)
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);

    task automatic write_modulus(input logic [8:0] m);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * gf2pi_pkg::REG_MODULUS);
        pwdata <= 32'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_operand(input logic [FD-1:0] op);
        i_valid <= 1'b1;
        i_operand_poly <= op;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic settle;
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic random_run(input int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n > 0; k++, n--)
                send_operand(FD'($urandom));
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    logic [8:0] moduli[6] = '{9'h11B, 9'h1FF, 9'h0FF, 9'h100, 9'h1E7, 9'h000};

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (moduli[i]) begin
            if (i == 0) begin
                // reset value, directed edge operands
                send_operand('0);
                send_operand('1);
                send_operand(8'h01);
                send_operand(8'h80);
                send_operand(8'h53);
                send_operand(8'hCA);
                send_operand(8'h55);
                send_operand(8'hAA);
                settle();
            end
            write_modulus(moduli[i]);
            if (i == 1) begin
                // all-ones modulus has factors x^2+x+1 and x^6+x^3+1
                send_operand(8'h07);
                send_operand(8'h0E);
                send_operand(8'h02);
                send_operand(8'h49);
            end
            random_run(i < 3 ? 370 : 140);
            settle();
        end
        write_modulus(9'h11B);
        random_run(100);
        settle();
        $display("covered %0d results over %0d modulus settings incl. reducible, "
                 , checked, 7);
        $display("wrong-degree and zero moduli, with bursty input and receiver stalls");
        if (fail_count == 0)
            $display("gf2_poly_inverse_euclid_unit_tb: clean");
        else
            $display("gf2_poly_inverse_euclid_unit_tb: errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("gf2_poly_inverse_euclid_unit_tb: errors");
        $finish;
    end
endmodule
